// ===== rtl/station_ap_association_table_top_assert.svh =====
// Assertion macros for the station to access point association table.
`ifndef STATION_AP_ASSOCIATION_TABLE_TOP_ASSERT_SVH
`define STATION_AP_ASSOCIATION_TABLE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define SAT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("association table check failed");
`define SAT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("association table check failed");
`else
`define SAT_ASSERT_NOW(label, ante, cons)
`define SAT_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/sat_pkg.sv =====
// Shared types and constants of the station to access point association table.
package sat_pkg;

	localparam int MAC_W             = 48;
	localparam int STATION_SLOTS_DEF = 32;
	localparam int AP_SLOTS_DEF      = 16;

	localparam logic [1:0] MODE_ASSOC  = 2'd0;
	localparam logic [1:0] MODE_LOOKUP = 2'd1;
	localparam logic [1:0] MODE_LIST   = 2'd2;

	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_REASSOC   = 3'd1;
	localparam logic [2:0] ST_NOT_FOUND = 3'd2;
	localparam logic [2:0] ST_STA_FULL  = 3'd3;
	localparam logic [2:0] ST_AP_FULL   = 3'd4;

	typedef struct packed {
		logic [2:0]       status;
		logic [MAC_W-1:0] station;
		logic [MAC_W-1:0] ap;
		logic [5:0]       count;
		logic             last;
	} res_t;

endpackage

// ===== rtl/sat_req_if.sv =====
// Request channel of the association table.
interface sat_req_if import sat_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [1:0]       mode;
	logic [MAC_W-1:0] client_mac;
	logic [MAC_W-1:0] ap_mac;

	modport source (output valid, mode, client_mac, ap_mac, input ready);
	modport sink (input valid, mode, client_mac, ap_mac, output ready);
endinterface

// ===== rtl/sat_rsp_if.sv =====
// Result channel of the association table.
interface sat_rsp_if import sat_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [2:0]       status;
	logic [MAC_W-1:0] result_station;
	logic [MAC_W-1:0] result_ap;
	logic [5:0]       ap_count;
	logic             last;

	modport source (output valid, status, result_station, result_ap, ap_count, last,
		input ready);
	modport sink (input valid, status, result_station, result_ap, ap_count, last,
		output ready);
endinterface

// ===== rtl/sat_ram.sv =====
// Synchronous table memory with registered read and a used flag per entry.
module sat_ram import sat_pkg::*; #(
	parameter int DEPTH = STATION_SLOTS_DEF,
	parameter int WIDTH = MAC_W
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic                     rd_used,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [DEPTH-1:0] used_q;
	logic             rd_used_q;
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q    <= '0;
			rd_used_q <= 1'b0;
		end else begin
			if (wr_en) begin
				used_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_used_q <= used_q[rd_addr];
			end
		end
	end

	assign rd_used = rd_used_q;
	assign rd_data = rd_data_q;

endmodule

// ===== rtl/sat_ctrl.sv =====
// Request sequencer: table scans, read-modify-write of counts and result output.
module sat_ctrl import sat_pkg::*; #(
	parameter int STATION_SLOTS = STATION_SLOTS_DEF,
	parameter int AP_SLOTS      = AP_SLOTS_DEF,
	localparam int SAW   = $clog2(STATION_SLOTS),
	localparam int AAW   = $clog2(AP_SLOTS),
	localparam int CNT_W = $clog2(STATION_SLOTS + 1),
	localparam int STA_W = MAC_W + AAW,
	localparam int AP_W  = MAC_W + CNT_W
) (
	input  logic             clk,
	input  logic             arst_n,
	sat_req_if.sink          req,
	sat_rsp_if.source        rsp,
	output logic             sta_rd_en,
	output logic [SAW-1:0]   sta_rd_addr,
	input  logic             sta_rd_used,
	input  logic [STA_W-1:0] sta_rd_data,
	output logic             sta_wr_en,
	output logic [SAW-1:0]   sta_wr_addr,
	output logic [STA_W-1:0] sta_wr_data,
	output logic             ap_rd_en,
	output logic [AAW-1:0]   ap_rd_addr,
	input  logic             ap_rd_used,
	input  logic [AP_W-1:0]  ap_rd_data,
	output logic             ap_wr_en,
	output logic [AAW-1:0]   ap_wr_addr,
	output logic [AP_W-1:0]  ap_wr_data
);

	localparam int IW = (SAW > AAW) ? SAW : AAW;
	localparam logic [IW:0] STA_LIM = (IW + 1)'(STATION_SLOTS);
	localparam logic [IW:0] AP_LIM  = (IW + 1)'(AP_SLOTS);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SSCAN = 4'd1;
	localparam logic [3:0] S_ASCAN = 4'd2;
	localparam logic [3:0] S_ORD   = 4'd3;
	localparam logic [3:0] S_OWAIT = 4'd4;
	localparam logic [3:0] S_WR    = 4'd5;
	localparam logic [3:0] S_ARD   = 4'd6;
	localparam logic [3:0] S_AWAIT = 4'd7;
	localparam logic [3:0] S_LSCAN = 4'd8;
	localparam logic [3:0] S_EMIT  = 4'd9;

	logic [3:0]       state_q;
	logic [1:0]       mode_q;
	logic [MAC_W-1:0] sta_q;
	logic [MAC_W-1:0] apm_q;
	logic [IW:0]      scan_idx_q;
	logic             chk_vld_s1;
	logic [IW-1:0]    chk_idx_s1;
	logic             free_vld_q;
	logic [IW-1:0]    free_idx_q;
	logic             s_found_q;
	logic [SAW-1:0]   s_idx_q;
	logic [AAW-1:0]   old_slot_q;
	logic [AAW-1:0]   a_idx_q;
	logic [CNT_W-1:0] cnt_q;
	logic             pend_vld_q;
	logic [MAC_W-1:0] pend_mac_q;
	res_t             res_q;
	logic             out_vld_q;
	res_t             out_res_q;

	logic [MAC_W-1:0] sta_rd_mac;
	logic [AAW-1:0]   sta_rd_slot;
	logic [MAC_W-1:0] ap_rd_mac;
	logic [CNT_W-1:0] ap_rd_cnt;
	logic [CNT_W-1:0] cnt_dec;
	logic [CNT_W-1:0] cnt_inc;
	logic             scanning;
	logic [IW:0]      lim;
	logic             hit;
	logic             chk_used;
	logic             out_free;
	logic             stall;
	logic             issue;
	logic             scan_end;
	logic             out_ld;
	res_t             out_ld_res;

	assign sta_rd_mac  = sta_rd_data[STA_W-1:AAW];
	assign sta_rd_slot = sta_rd_data[AAW-1:0];
	assign ap_rd_mac   = ap_rd_data[AP_W-1:CNT_W];
	assign ap_rd_cnt   = ap_rd_data[CNT_W-1:0];
	assign cnt_dec     = (ap_rd_cnt != '0) ? ap_rd_cnt - 1'b1 : ap_rd_cnt;
	assign cnt_inc     = cnt_q + 1'b1;

	always_comb begin
		scanning = state_q inside {S_SSCAN, S_ASCAN, S_LSCAN};
		lim      = (state_q == S_ASCAN) ? AP_LIM : STA_LIM;
		chk_used = (state_q == S_ASCAN) ? ap_rd_used : sta_rd_used;
		case (state_q)
			S_SSCAN: hit = chk_vld_s1 && sta_rd_used && (sta_rd_mac == sta_q);
			S_ASCAN: hit = chk_vld_s1 && ap_rd_used && (ap_rd_mac == apm_q);
			S_LSCAN: hit = chk_vld_s1 && sta_rd_used && (sta_rd_slot == a_idx_q);
			default: hit = 1'b0;
		endcase
		out_free = !out_vld_q || rsp.ready;
		stall    = (state_q == S_LSCAN) && hit && pend_vld_q && !out_free;
		issue    = scanning && (scan_idx_q < lim) && !stall;
		scan_end = scanning && !chk_vld_s1 && (scan_idx_q == lim);
		out_ld   = ((state_q == S_EMIT) && out_free) ||
			((state_q == S_LSCAN) && hit && pend_vld_q && out_free);
		if (state_q == S_EMIT) begin
			out_ld_res = res_q;
		end else begin
			out_ld_res = '{ST_OK, pend_mac_q, apm_q, 6'(cnt_q), 1'b0};
		end
	end

	always_comb begin
		sta_rd_en   = issue && (state_q != S_ASCAN);
		sta_rd_addr = scan_idx_q[SAW-1:0];
		sta_wr_en   = (state_q == S_WR);
		sta_wr_addr = s_idx_q;
		sta_wr_data = {sta_q, a_idx_q};
		ap_rd_en    = (issue && (state_q == S_ASCAN)) || (state_q == S_ORD) ||
			(state_q == S_ARD);
		ap_rd_addr  = (state_q == S_ASCAN) ? scan_idx_q[AAW-1:0] : old_slot_q;
		ap_wr_en    = ((state_q == S_OWAIT) && (old_slot_q != a_idx_q)) ||
			(state_q == S_WR);
		if (state_q == S_WR) begin
			ap_wr_addr = a_idx_q;
			ap_wr_data = {apm_q, cnt_inc};
		end else begin
			ap_wr_addr = old_slot_q;
			ap_wr_data = {ap_rd_mac, cnt_dec};
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			mode_q <= req.mode;
			sta_q  <= req.client_mac;
			apm_q  <= req.ap_mac;
		end
		if (issue) begin
			chk_idx_s1 <= scan_idx_q[IW-1:0];
		end
		if (scanning && chk_vld_s1 && !chk_used && !free_vld_q) begin
			free_idx_q <= chk_idx_s1;
		end
		if (out_ld) begin
			out_res_q <= out_ld_res;
		end
		case (state_q)
			S_SSCAN: begin
				if (hit) begin
					s_found_q  <= 1'b1;
					s_idx_q    <= chk_idx_s1[SAW-1:0];
					old_slot_q <= sta_rd_slot;
				end else if (scan_end) begin
					s_found_q <= 1'b0;
					s_idx_q   <= free_idx_q[SAW-1:0];
					if (mode_q == MODE_LOOKUP) begin
						res_q <= '{ST_NOT_FOUND, sta_q, '0, '0, 1'b1};
					end else begin
						res_q <= '{ST_STA_FULL, sta_q, apm_q, '0, 1'b1};
					end
				end
			end
			S_ASCAN: begin
				if (hit) begin
					a_idx_q <= chk_idx_s1[AAW-1:0];
					cnt_q   <= ap_rd_cnt;
				end else if (scan_end) begin
					a_idx_q <= free_idx_q[AAW-1:0];
					cnt_q   <= '0;
					if (mode_q == MODE_LIST) begin
						res_q <= '{ST_NOT_FOUND, '0, apm_q, '0, 1'b1};
					end else begin
						res_q <= '{ST_AP_FULL, sta_q, apm_q, '0, 1'b1};
					end
				end
			end
			S_OWAIT: begin
				if (old_slot_q == a_idx_q) begin
					cnt_q <= cnt_dec;
				end
			end
			S_WR: begin
				res_q <= '{(s_found_q ? ST_REASSOC : ST_OK), sta_q, apm_q,
					6'(cnt_inc), 1'b1};
			end
			S_AWAIT: begin
				res_q <= '{ST_OK, sta_q, ap_rd_mac, 6'(ap_rd_cnt), 1'b1};
			end
			S_LSCAN: begin
				if (hit && !stall) begin
					pend_mac_q <= sta_rd_mac;
				end else if (scan_end) begin
					if (pend_vld_q) begin
						res_q <= '{ST_OK, pend_mac_q, apm_q, 6'(cnt_q), 1'b1};
					end else begin
						res_q <= '{ST_NOT_FOUND, '0, apm_q, '0, 1'b1};
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			scan_idx_q <= '0;
			chk_vld_s1 <= 1'b0;
			free_vld_q <= 1'b0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (out_ld) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			if (issue) begin
				scan_idx_q <= scan_idx_q + 1'b1;
				chk_vld_s1 <= 1'b1;
			end else if (!stall) begin
				chk_vld_s1 <= 1'b0;
			end
			if (scanning && chk_vld_s1 && !chk_used && !free_vld_q) begin
				free_vld_q <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					scan_idx_q <= '0;
					chk_vld_s1 <= 1'b0;
					free_vld_q <= 1'b0;
					pend_vld_q <= 1'b0;
					if (req.valid) begin
						case (req.mode)
							MODE_ASSOC, MODE_LOOKUP: state_q <= S_SSCAN;
							MODE_LIST: state_q <= S_ASCAN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_SSCAN: begin
					if (hit || scan_end) begin
						scan_idx_q <= '0;
						chk_vld_s1 <= 1'b0;
						free_vld_q <= 1'b0;
					end
					if (hit) begin
						state_q <= (mode_q == MODE_LOOKUP) ? S_ARD : S_ASCAN;
					end else if (scan_end) begin
						if (mode_q == MODE_LOOKUP || !free_vld_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= S_ASCAN;
						end
					end
				end
				S_ASCAN: begin
					if (hit || scan_end) begin
						scan_idx_q <= '0;
						chk_vld_s1 <= 1'b0;
						free_vld_q <= 1'b0;
					end
					if (hit) begin
						if (mode_q == MODE_LIST) begin
							state_q <= S_LSCAN;
						end else begin
							state_q <= s_found_q ? S_ORD : S_WR;
						end
					end else if (scan_end) begin
						if (mode_q == MODE_LIST || !free_vld_q) begin
							state_q <= S_EMIT;
						end else begin
							state_q <= s_found_q ? S_ORD : S_WR;
						end
					end
				end
				S_ORD: state_q <= S_OWAIT;
				S_OWAIT: state_q <= S_WR;
				S_WR: state_q <= S_EMIT;
				S_ARD: state_q <= S_AWAIT;
				S_AWAIT: state_q <= S_EMIT;
				S_LSCAN: begin
					if (hit && !stall) begin
						pend_vld_q <= 1'b1;
					end else if (scan_end) begin
						scan_idx_q <= '0;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = out_vld_q;
	assign rsp.status         = out_res_q.status;
	assign rsp.result_station = out_res_q.station;
	assign rsp.result_ap      = out_res_q.ap;
	assign rsp.ap_count       = out_res_q.count;
	assign rsp.last           = out_res_q.last;

endmodule

// ===== rtl/station_ap_association_table_top.sv =====
// Top level of the station to access point association table.
// One request at a time; each table search reads one memory entry per cycle,
// except that a list scan holds while a found station waits on a busy output.
// The next request is accepted in the cycle after the last result loads into the output register.
// Asynchronous reset clears the used flags of both tables, the state, the scan index and the valid flags.
`include "station_ap_association_table_top_assert.svh"
module station_ap_association_table_top import sat_pkg::*; #(
	parameter int STATION_SLOTS = STATION_SLOTS_DEF,
	parameter int AP_SLOTS      = AP_SLOTS_DEF
) (
	input logic       clk,
	input logic       arst_n,
	sat_req_if.sink   req,
	sat_rsp_if.source rsp
);

	localparam int SAW   = $clog2(STATION_SLOTS);
	localparam int AAW   = $clog2(AP_SLOTS);
	localparam int CNT_W = $clog2(STATION_SLOTS + 1);
	localparam int STA_W = MAC_W + AAW;
	localparam int AP_W  = MAC_W + CNT_W;

	logic             sta_rd_en;
	logic [SAW-1:0]   sta_rd_addr;
	logic             sta_rd_used;
	logic [STA_W-1:0] sta_rd_data;
	logic             sta_wr_en;
	logic [SAW-1:0]   sta_wr_addr;
	logic [STA_W-1:0] sta_wr_data;
	logic             ap_rd_en;
	logic [AAW-1:0]   ap_rd_addr;
	logic             ap_rd_used;
	logic [AP_W-1:0]  ap_rd_data;
	logic             ap_wr_en;
	logic [AAW-1:0]   ap_wr_addr;
	logic [AP_W-1:0]  ap_wr_data;

	sat_ram #(
		.DEPTH(STATION_SLOTS),
		.WIDTH(STA_W)
	) u_sta_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(sta_rd_en),
		.rd_addr(sta_rd_addr),
		.rd_used(sta_rd_used),
		.rd_data(sta_rd_data),
		.wr_en(sta_wr_en),
		.wr_addr(sta_wr_addr),
		.wr_data(sta_wr_data)
	);

	sat_ram #(
		.DEPTH(AP_SLOTS),
		.WIDTH(AP_W)
	) u_ap_ram (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(ap_rd_en),
		.rd_addr(ap_rd_addr),
		.rd_used(ap_rd_used),
		.rd_data(ap_rd_data),
		.wr_en(ap_wr_en),
		.wr_addr(ap_wr_addr),
		.wr_data(ap_wr_data)
	);

	sat_ctrl #(
		.STATION_SLOTS(STATION_SLOTS),
		.AP_SLOTS(AP_SLOTS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.sta_rd_en(sta_rd_en),
		.sta_rd_addr(sta_rd_addr),
		.sta_rd_used(sta_rd_used),
		.sta_rd_data(sta_rd_data),
		.sta_wr_en(sta_wr_en),
		.sta_wr_addr(sta_wr_addr),
		.sta_wr_data(sta_wr_data),
		.ap_rd_en(ap_rd_en),
		.ap_rd_addr(ap_rd_addr),
		.ap_rd_used(ap_rd_used),
		.ap_rd_data(ap_rd_data),
		.ap_wr_en(ap_wr_en),
		.ap_wr_addr(ap_wr_addr),
		.ap_wr_data(ap_wr_data)
	);

	`SAT_ASSERT_NOW(a_err_single, rsp.valid && (rsp.status != ST_OK), rsp.last)
	`SAT_ASSERT_NOW(a_miss_no_count, rsp.valid && (rsp.status == ST_NOT_FOUND), rsp.ap_count == '0)
	`SAT_ASSERT_NOW(a_full_no_count, rsp.valid && (rsp.status > ST_NOT_FOUND), rsp.ap_count == '0)
	`SAT_ASSERT_NEXT(a_busy_after_req, req.valid && req.ready && (req.mode <= MODE_LIST), !req.ready)

endmodule
